### hdl/ufr_pkg.sv
package ufr_pkg;

  localparam logic [7:0] START_BYTE   = 8'h3A;
  localparam int         TIME_COUNT   = 6;
  localparam logic [1:0] HDR_ADDRESS  = 2'd1;
  localparam logic [1:0] HDR_LENGTH   = 2'd2;
  localparam logic [1:0] HDR_FUNCTION = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]                      dest_address;
    logic [7:0]                      data_count;
    logic [7:0]                      function_code;
    logic [TIME_COUNT-1:0][7:0]      time_b;
    logic                            indicator_level;
  } frame_t;

endpackage

### hdl/uart_frame_receiver_top.sv
// channel | signals                 | payload
// input   | in_valid / in_stall     | rx_byte
// output  | out_valid / out_stall   | header fields, time_0..time_5, indicator_level
//
// One byte per cycle while in_stall is low. A byte is first held in the input
// register, then the parser updates its state; a completing byte loads the
// result register as the terminator leaves the input register.
// rst is synchronous; parser time bytes clear to zero, its indicator starts high.
// in_stall rises only while a result waits and the held byte completes a frame.
module uart_frame_receiver_top
  import ufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] dest_address,
  output logic [7:0] data_count,
  output logic [7:0] function_code,
  output logic [7:0] time_0,
  output logic [7:0] time_1,
  output logic [7:0] time_2,
  output logic [7:0] time_3,
  output logic [7:0] time_4,
  output logic [7:0] time_5,
  output logic       indicator_level
);

  logic       held;
  logic [7:0] held_byte;
  logic       advance;
  logic       done;
  frame_t     frame;
  frame_t     result;

  // bytes that don't finish a frame never wait on the output side
  assign advance = held && (!done || !out_valid || !out_stall);

  ufr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .held      (held),
    .held_byte (held_byte)
  );

  ufr_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .rx_byte (held_byte),
    .done    (done),
    .frame   (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      result <= frame;
    end
  end

  assign dest_address    = result.dest_address;
  assign data_count      = result.data_count;
  assign function_code   = result.function_code;
  assign time_0          = result.time_b[0];
  assign time_1          = result.time_b[1];
  assign time_2          = result.time_b[2];
  assign time_3          = result.time_b[3];
  assign time_4          = result.time_b[4];
  assign time_5          = result.time_b[5];
  assign indicator_level = result.indicator_level;

endmodule

### hdl/ufr_in_stage.sv
module ufr_in_stage
  import ufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held,
  output logic [7:0] held_byte
);

  logic accept;

  assign in_stall = held && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

### hdl/ufr_parser.sv
module ufr_parser
  import ufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       done,
  output frame_t     frame
);

  phase_t                      phase, phase_next;
  logic [7:0]                  byte_index, byte_index_next;
  logic [7:0]                  hdr_address, hdr_length, hdr_function;
  logic [TIME_COUNT-1:0][7:0]  time_bytes;
  logic                        indicator;

  // length byte doubles as the payload length while in the payload phase
  assign done = (phase == PH_PAYLOAD) && (byte_index >= hdr_length);

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    case (phase)
      PH_PAYLOAD: begin
        if (done) begin
          phase_next = PH_IDLE;
        end else begin
          byte_index_next = byte_index + 8'd1;
        end
      end
      PH_HEADER: begin
        if (byte_index[1:0] == HDR_FUNCTION) begin
          phase_next      = PH_PAYLOAD;
          byte_index_next = 8'd0;
        end else begin
          byte_index_next = byte_index + 8'd1;
        end
      end
      default: begin
        if (rx_byte == START_BYTE) begin
          phase_next      = PH_HEADER;
          byte_index_next = 8'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_index <= '0;
      time_bytes <= '0;
      indicator  <= 1'b1;
    end else if (take) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      if (phase == PH_PAYLOAD && !done && byte_index < 8'(TIME_COUNT)) begin
        time_bytes[byte_index[2:0]] <= rx_byte;
      end
      if (done) begin
        indicator <= ~indicator;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase == PH_HEADER) begin
      case (byte_index[1:0])
        HDR_ADDRESS:  hdr_address  <= rx_byte;
        HDR_LENGTH:   hdr_length   <= rx_byte;
        HDR_FUNCTION: hdr_function <= rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    frame.dest_address    = hdr_address;
    frame.data_count      = hdr_length;
    frame.function_code   = hdr_function;
    frame.time_b          = time_bytes;
    frame.indicator_level = ~indicator;
  end

endmodule

### hdl/ufr_checker.sv
module ufr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] dest_address,
  input logic       indicator_level
);

  // input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no waiting result");

  // a frame is at least five bytes plus the input register
  a_min_frame: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result too soon after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(dest_address) && $stable(indicator_level)))
    else $error("result changed while stalled");

endmodule

bind uart_frame_receiver_top ufr_checker u_ufr_checker (.*);

### dv/uart_frame_receiver_top_tb.sv
module uart_frame_receiver_top_tb;
  import ufr_pkg::*;

  localparam int         HDR_BYTES   = 4;
  localparam int         IDLE_PCT    = 13;
  localparam int         HOLD_CYCLES = 120;
  localparam int         STUCK_LIMIT = 5000;
  localparam int         RAND_ITEMS  = 2000;
  localparam int         MAX_REPORTS = 10;
  localparam int         DRAIN_WAIT  = 20;
  localparam logic [7:0] CR          = 8'h0D;
  localparam logic [7:0] LF          = 8'h0A;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] dest_address;
  logic [7:0] data_count;
  logic [7:0] function_code;
  logic [7:0] time_0, time_1, time_2, time_3, time_4, time_5;
  logic       indicator_level;

  // deframer model state
  phase_t     rx_phase;
  logic [7:0] rx_pos;
  logic [7:0] rx_len;
  logic [7:0] rx_hdr [HDR_BYTES];
  logic [7:0] rx_time [TIME_COUNT];
  logic       rx_ind;
  frame_t     frame_q [$];

  int mismatches = 0;
  int requests_sent = 0;
  int stuck = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  uart_frame_receiver_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .dest_address    (dest_address),
    .data_count      (data_count),
    .function_code   (function_code),
    .time_0          (time_0),
    .time_1          (time_1),
    .time_2          (time_2),
    .time_3          (time_3),
    .time_4          (time_4),
    .time_5          (time_5),
    .indicator_level (indicator_level)
  );

  always #10 clk = ~clk;

  // Returns 0 when the byte is dropped as idle noise.
  function automatic bit predict_rx(input logic [7:0] b);
    bit     done;
    bit     used;
    frame_t f;
    done = 1'b0;
    used = 1'b1;
    case (rx_phase)
      PH_PAYLOAD: begin
        if (rx_pos < rx_len) begin
          if (rx_pos < TIME_COUNT) rx_time[rx_pos] = b;
          rx_pos = rx_pos + 8'd1;
        end else begin
          // terminator is not checked
          rx_phase = PH_IDLE;
          done = 1'b1;
        end
      end
      PH_HEADER: begin
        rx_hdr[rx_pos[1:0]] = b;
        rx_pos = rx_pos + 8'd1;
      end
      default: begin
        if (b == START_BYTE) begin
          rx_phase = PH_HEADER;
          rx_hdr[0] = b;
          rx_pos = 8'd1;
        end else begin
          used = 1'b0;
        end
      end
    endcase
    if (rx_phase == PH_HEADER && rx_pos >= HDR_BYTES) begin
      rx_len = rx_hdr[HDR_LENGTH];
      rx_phase = PH_PAYLOAD;
      rx_pos = 8'd0;
    end
    if (done) begin
      rx_ind = ~rx_ind;
      f.dest_address = rx_hdr[HDR_ADDRESS];
      f.data_count = rx_hdr[HDR_LENGTH];
      f.function_code = rx_hdr[HDR_FUNCTION];
      for (int k = 0; k < TIME_COUNT; k++) f.time_b[k] = rx_time[k];
      f.indicator_level = rx_ind;
      frame_q.push_back(f);
    end
    return used;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_rx(b)) requests_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                            input logic [7:0] fn, input logic [7:0] term, input bit trail);
    send_byte(START_BYTE);
    send_byte(addr);
    send_byte(len);
    send_byte(fn);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
    send_byte(term);
    if (trail) send_byte(LF);
  endtask

  task automatic test_idle_noise();
    send_byte(LF);
    send_byte(8'hFF);
  endtask

  // start byte as terminator must close the frame, not open a new one
  task automatic test_zero_length();
    send_frame(8'hFF, 8'd0, 8'h00, START_BYTE, 1'b1);
  endtask

  task automatic test_payload_overflow();
    send_frame(8'h00, 8'd7, 8'hFF, CR, 1'b0);
  endtask

  // time bytes 2..5 keep the previous frame's values
  task automatic test_short_payload();
    send_frame(8'h5A, 8'd2, 8'hA5, CR, 1'b0);
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_reqs <= hold_reqs + 1;
    repeat (8) send_frame(8'($urandom), 8'($urandom_range(3)), 8'($urandom), CR, 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    int base;
    int pick;
    int frames;
    logic [7:0] len;
    base = requests_sent;
    frames = 0;
    while (requests_sent - base < RAND_ITEMS) begin
      quiet = (requests_sent - base > 800) && (requests_sent - base < 1200);
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = (frames % 60 == 3) ? 8'd255 : 8'($urandom_range(12));
        send_frame(8'($urandom), len, 8'($urandom),
                   ($urandom_range(9) == 0) ? 8'($urandom) : CR, 1'($urandom_range(1)));
        frames++;
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else begin
        // truncated header; following bytes get absorbed into the frame
        send_byte(START_BYTE);
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(15)));
      end
    end
    quiet = 1'b0;
  endtask

  // result side
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_frame
    frame_t want;
    frame_t got;
    if (!rst && out_valid && !out_stall) begin
      got.dest_address = dest_address;
      got.data_count = data_count;
      got.function_code = function_code;
      got.time_b = {time_5, time_4, time_3, time_2, time_1, time_0};
      got.indicator_level = indicator_level;
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected frame: addr %h len %h fn %h time %h ind %b",
                   got.dest_address, got.data_count, got.function_code,
                   got.time_b, got.indicator_level);
      end else begin
        want = frame_q.pop_front();
        if (got.dest_address !== want.dest_address || got.data_count !== want.data_count ||
            got.function_code !== want.function_code || got.time_b !== want.time_b ||
            got.indicator_level !== want.indicator_level) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"frame mismatch: exp addr %h len %h fn %h time %h ind %b",
                      " / got addr %h len %h fn %h time %h ind %b"},
                     want.dest_address, want.data_count, want.function_code,
                     want.time_b, want.indicator_level,
                     got.dest_address, got.data_count, got.function_code,
                     got.time_b, got.indicator_level);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    rx_phase = PH_IDLE;
    rx_pos = 8'd0;
    rx_len = 8'd0;
    rx_ind = 1'b1;
    for (int k = 0; k < HDR_BYTES; k++) rx_hdr[k] = 8'd0;
    for (int k = 0; k < TIME_COUNT; k++) rx_time[k] = 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_noise();
    test_zero_length();
    test_payload_overflow();
    test_short_payload();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ufr_pkg.sv
hdl/ufr_in_stage.sv
hdl/ufr_parser.sv
hdl/uart_frame_receiver_top.sv
hdl/ufr_checker.sv
dv/uart_frame_receiver_top_tb.sv
